/* rtl/millisecond_timer_pool_unit_defines.svh */
// ----------------------------------------------------------------------------
// Millisecond timer pool assertion macros
// Shared property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef MILLISECOND_TIMER_POOL_UNIT_DEFINES_SVH
`define MILLISECOND_TIMER_POOL_UNIT_DEFINES_SVH

// property checked outside reset
`define MTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mtp_pkg.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool package
// Sizes, operation and status codes, controller state and interface structs
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 24;

    localparam int OP_W      = 2;
    localparam int DUR_W     = 24;
    localparam int ID_W      = 4;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_W    = SLOT_W + 1;
    localparam int SID_EXT_W = SLOT_W + ID_W;
    localparam int EXT_W     = 33;

    localparam logic [EXT_W-1:0] COUNT_MAX_EXT = EXT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CMD,
        S_TICK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic start_step;
        logic start_claim;
        logic start_full;
        logic cmd_exec;
        logic tick_run;
        logic flush_emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic cand_free;
        logic scan_done;
        logic tick_done;
        logic pend_valid;
    } t_ctl_sts;

    function automatic logic [COUNT_WIDTH-1:0] sat_duration(input logic [DUR_W-1:0] dur);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(dur);
        if (ext > COUNT_MAX_EXT) begin
            ext = COUNT_MAX_EXT;
        end
        return ext[COUNT_WIDTH-1:0];
    endfunction

endpackage

/* rtl/mtp_ctrl.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool controller
// Sequences request intake, slot search, commands, tick walk and final report
// ----------------------------------------------------------------------------
module mtp_ctrl
    import mtp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_operation,
    input  t_ctl_sts        i_sts,
    output logic            o_in_ready,
    output t_ctl_cmd        o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_operation)
                        OP_START:          n_state = S_START;
                        OP_TICK:           n_state = S_TICK;
                        OP_STOP, OP_RESET: n_state = S_CMD;
                        default:           n_state = S_CMD;
                    endcase
                end
            end
            S_START: begin
                priority if (i_sts.scan_done) begin
                    if (i_sts.out_free) begin
                        o_cmd.start_full = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.cand_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.start_claim = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.start_step = 1'b1;
                end
            end
            S_CMD: begin
                if (i_sts.out_free) begin
                    o_cmd.cmd_exec = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.tick_done) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.tick_run = 1'b1;
                end
            end
            S_FLUSH: begin
                priority if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush_emit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/mtp_dpath.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool datapath
// Slot flags, count and length memories, scan pipeline and result register
// ----------------------------------------------------------------------------
module mtp_dpath
    import mtp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl_cmd            i_cmd,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DUR_W-1:0]    i_duration_ms,
    input  logic [ID_W-1:0]     i_slot_id,
    input  logic                i_out_ready,
    output t_ctl_sts            o_sts,
    output logic                o_out_valid,
    output logic                o_kind,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_result_id,
    output logic                o_last
);

    logic [COUNT_WIDTH-1:0] r_elapsed [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_timeout [NUM_TIMERS];

    logic [NUM_TIMERS-1:0]  r_active, n_active;
    logic [SLOT_W-1:0]      r_next, n_next;
    logic [SCAN_W-1:0]      r_scan, n_scan;
    logic [OP_W-1:0]        r_op;
    logic [COUNT_WIDTH-1:0] r_dur;
    logic [ID_W-1:0]        r_sid;

    logic                   r_p_valid, n_p_valid;
    logic [SLOT_W-1:0]      r_p_idx;
    logic [COUNT_WIDTH-1:0] r_el_q;
    logic [COUNT_WIDTH-1:0] r_to_q;
    logic                   r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]      r_pend_idx, n_pend_idx;

    logic                   r_out_valid, n_out_valid;
    logic                   r_kind, n_kind;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [ID_W-1:0]        r_rid, n_rid;
    logic                   r_last, n_last;

    logic                   out_free;
    logic [SCAN_W-1:0]      cand_sum;
    logic [SLOT_W-1:0]      cand;
    logic [SCAN_W-1:0]      cand_inc;
    logic [SID_EXT_W-1:0]   sid_ext;
    logic [SLOT_W-1:0]      sid_idx;
    logic                   sid_hit;
    logic                   scan_done;
    logic                   p_active;
    logic [COUNT_WIDTH-1:0] el_inc;
    logic                   p_expire;
    logic                   stall;
    logic                   tick_go;
    logic                   rd_en;
    logic                   we_el;
    logic [SLOT_W-1:0]      we_el_addr;
    logic [COUNT_WIDTH-1:0] we_el_data;

    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_done = (r_scan == SCAN_W'(NUM_TIMERS));

    // round-robin candidate, next pointer plus scan offset
    always_comb begin
        cand_sum = SCAN_W'(r_next) + r_scan;
        if (cand_sum >= SCAN_W'(NUM_TIMERS)) begin
            cand_sum = cand_sum - SCAN_W'(NUM_TIMERS);
        end
        cand     = cand_sum[SLOT_W-1:0];
        cand_inc = SCAN_W'(cand) + SCAN_W'(1);
        if (cand_inc == SCAN_W'(NUM_TIMERS)) begin
            cand_inc = '0;
        end
    end

    assign sid_ext = SID_EXT_W'(r_sid);
    assign sid_idx = sid_ext[SLOT_W-1:0];
    assign sid_hit = (sid_ext < SID_EXT_W'(NUM_TIMERS)) && r_active[sid_idx];

    // tick evaluation stage
    assign p_active = r_active[r_p_idx];
    assign el_inc   = (r_el_q == {COUNT_WIDTH{1'b1}}) ? r_el_q : r_el_q + COUNT_WIDTH'(1);
    assign p_expire = r_p_valid && p_active && (el_inc >= r_to_q);
    assign stall    = p_expire && r_pend_valid && !out_free;
    assign tick_go  = i_cmd.tick_run && !stall;
    assign rd_en    = tick_go && !scan_done;

    assign o_sts.out_free   = out_free;
    assign o_sts.cand_free  = !r_active[cand];
    assign o_sts.scan_done  = scan_done;
    assign o_sts.tick_done  = scan_done && !r_p_valid;
    assign o_sts.pend_valid = r_pend_valid;

    always_comb begin
        n_active     = r_active;
        n_next       = r_next;
        n_scan       = r_scan;
        n_p_valid    = r_p_valid;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_kind       = r_kind;
        n_status     = r_status;
        n_rid        = r_rid;
        n_last       = r_last;
        we_el        = 1'b0;
        we_el_addr   = cand;
        we_el_data   = '0;

        if (i_cmd.load) begin
            n_scan       = '0;
            n_p_valid    = 1'b0;
            n_pend_valid = 1'b0;
        end

        if (i_cmd.start_step) begin
            n_scan = r_scan + SCAN_W'(1);
        end

        if (i_cmd.start_claim) begin
            n_active[cand] = 1'b1;
            n_next         = cand_inc[SLOT_W-1:0];
            we_el          = 1'b1;
            we_el_addr     = cand;
            n_out_valid    = 1'b1;
            n_kind         = KIND_ANSWER;
            n_status       = ST_OK;
            n_rid          = ID_W'(cand);
            n_last         = 1'b1;
        end

        if (i_cmd.start_full) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_ANSWER;
            n_status    = ST_NO_SLOT;
            n_rid       = '0;
            n_last      = 1'b1;
        end

        if (i_cmd.cmd_exec) begin
            if (sid_hit) begin
                if (r_op == OP_STOP) begin
                    n_active[sid_idx] = 1'b0;
                end else begin
                    we_el      = 1'b1;
                    we_el_addr = sid_idx;
                end
            end
            n_out_valid = 1'b1;
            n_kind      = KIND_ANSWER;
            n_status    = sid_hit ? ST_OK : ST_NOT_FOUND;
            n_rid       = r_sid;
            n_last      = 1'b1;
        end

        if (tick_go) begin
            if (r_p_valid && p_active) begin
                we_el      = 1'b1;
                we_el_addr = r_p_idx;
                we_el_data = el_inc;
            end
            if (p_expire) begin
                n_active[r_p_idx] = 1'b0;
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_EXPIRY;
                    n_status    = ST_OK;
                    n_rid       = ID_W'(r_pend_idx);
                    n_last      = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_idx   = r_p_idx;
            end
            n_p_valid = !scan_done;
            if (!scan_done) begin
                n_scan = r_scan + SCAN_W'(1);
            end
        end

        if (i_cmd.flush_emit) begin
            n_out_valid  = 1'b1;
            n_kind       = KIND_EXPIRY;
            n_status     = ST_OK;
            n_rid        = ID_W'(r_pend_idx);
            n_last       = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_next       <= '0;
            r_scan       <= '0;
            r_p_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_next       <= n_next;
            r_scan       <= n_scan;
            r_p_valid    <= n_p_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_kind     <= n_kind;
        r_status   <= n_status;
        r_rid      <= n_rid;
        r_last     <= n_last;
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_dur <= sat_duration(i_duration_ms);
            r_sid <= i_slot_id;
        end
        if (rd_en) begin
            r_p_idx <= r_scan[SLOT_W-1:0];
        end
    end

    // elapsed count memory
    always_ff @(posedge i_clk) begin
        if (we_el) begin
            r_elapsed[we_el_addr] <= we_el_data;
        end
        if (rd_en) begin
            r_el_q <= r_elapsed[r_scan[SLOT_W-1:0]];
        end
    end

    // timeout length memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_claim) begin
            r_timeout[cand] <= r_dur;
        end
        if (rd_en) begin
            r_to_q <= r_timeout[r_scan[SLOT_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_status    = r_status;
    assign o_result_id = r_rid;
    assign o_last      = r_last;

endmodule

/* rtl/millisecond_timer_pool_unit.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool unit
// Pool of one-shot timers driven by start, stop, reset and tick requests
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        i_in_valid / o_in_ready   i_operation, i_duration_ms, i_slot_id
//  out       o_out_valid / i_out_ready o_kind, o_status, o_result_id, o_last
//
//  one request at a time; ready again once its last result is registered
//  start: one slot flag checked per cycle
//  tick: one memory read per slot
//  a full output register stalls the scan; synchronous reset frees every slot
// ----------------------------------------------------------------------------
module millisecond_timer_pool_unit
    import mtp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DUR_W-1:0]    i_duration_ms,
    input  logic [ID_W-1:0]     i_slot_id,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_result_id,
    output logic                o_last
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    mtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    mtp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_duration_ms (i_duration_ms),
        .i_slot_id     (i_slot_id),
        .i_out_ready   (i_out_ready),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_result_id   (o_result_id),
        .o_last        (o_last)
    );

endmodule

/* rtl/mtp_checker.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool port checker
// Result channel rules seen on the top level ports
// ----------------------------------------------------------------------------
`include "millisecond_timer_pool_unit_defines.svh"

module mtp_checker
    import mtp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_kind,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_result_id,
    input logic                o_last
);

    `MTP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_status) && $stable(o_result_id) && $stable(o_last), "result changed while stalled")

    `MTP_ASSERT(a_answer_last, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_ANSWER) |-> o_last, "command answer without last mark")

    `MTP_ASSERT(a_expiry_ok, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_EXPIRY) |-> (o_status == ST_OK), "expiry report with error status")

    `MTP_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status == ST_OK) || (o_status == ST_NO_SLOT) || (o_status == ST_NOT_FOUND), "undefined status code")

    `MTP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind millisecond_timer_pool_unit mtp_checker u_mtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_status    (o_status),
    .o_result_id (o_result_id),
    .o_last      (o_last)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Millisecond timer pool testbench
// Drives start, stop, reset and tick requests into the timer pool with random
// gaps and output back-pressure. A local model of the pool predicts every
// answer and expiry report, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    import mtp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int EXP_DEPTH     = 64;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic                last;
    } t_timer_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_operation;
    logic [DUR_W-1:0]    i_duration_ms;
    logic [ID_W-1:0]     i_slot_id;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_kind;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_result_id;
    logic                o_last;

    // local copy of the pool
    logic                   pool_busy    [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] pool_elapsed [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] pool_limit   [NUM_TIMERS];
    int                     pool_next;

    // expected results in arrival order
    t_timer_result exp_ring [EXP_DEPTH];
    int            exp_head;
    int            exp_tail;
    int            exp_count;

    bit idle_enable;
    bit stall_enable;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int expiry_reports;
    int full_answers;
    int cycle_count;

    millisecond_timer_pool_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_duration_ms (i_duration_ms),
        .i_slot_id     (i_slot_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_result_id   (o_result_id),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, exp_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic void store_expected(input t_timer_result r);
        exp_ring[exp_tail] = r;
        exp_tail           = (exp_tail + 1) % EXP_DEPTH;
        exp_count++;
    endfunction

    function automatic t_timer_result fetch_expected();
        t_timer_result r;
        r        = exp_ring[exp_head];
        exp_head = (exp_head + 1) % EXP_DEPTH;
        exp_count--;
        return r;
    endfunction

    function automatic void expect_result(input logic kind, input logic [STATUS_W-1:0] status,
                                          input logic [ID_W-1:0] id, input logic last);
        t_timer_result r;
        r.kind   = kind;
        r.status = status;
        r.id     = id;
        r.last   = last;
        store_expected(r);
    endfunction

    function automatic void predict_pool(input logic [OP_W-1:0] op,
                                         input logic [DUR_W-1:0] dur,
                                         input logic [ID_W-1:0] sid);
        int s;
        int n;
        int hits [NUM_TIMERS];
        int hit_count;
        bit claimed;
        claimed   = 1'b0;
        hit_count = 0;
        if (op == OP_START) begin
            for (n = 0; n < NUM_TIMERS && !claimed; n++) begin
                s = (pool_next + n) % NUM_TIMERS;
                if (!pool_busy[s]) begin
                    claimed         = 1'b1;
                    pool_busy[s]    = 1'b1;
                    pool_elapsed[s] = '0;
                    pool_limit[s]   = (EXT_W'(dur) > COUNT_MAX_EXT) ?
                                      COUNT_MAX_EXT[COUNT_WIDTH-1:0] : COUNT_WIDTH'(dur);
                    pool_next       = (s + 1) % NUM_TIMERS;
                    expect_result(KIND_ANSWER, ST_OK, ID_W'(s), 1'b1);
                end
            end
            if (!claimed) begin
                full_answers++;
                expect_result(KIND_ANSWER, ST_NO_SLOT, '0, 1'b1);
            end
        end else if (op == OP_STOP || op == OP_RESET) begin
            if (int'(sid) < NUM_TIMERS && pool_busy[sid]) begin
                if (op == OP_STOP) begin
                    pool_busy[sid] = 1'b0;
                end else begin
                    pool_elapsed[sid] = '0;
                end
                expect_result(KIND_ANSWER, ST_OK, sid, 1'b1);
            end else begin
                expect_result(KIND_ANSWER, ST_NOT_FOUND, sid, 1'b1);
            end
        end else begin
            for (s = 0; s < NUM_TIMERS; s++) begin
                if (pool_busy[s]) begin
                    if (pool_elapsed[s] != COUNT_MAX_EXT[COUNT_WIDTH-1:0]) begin
                        pool_elapsed[s] = pool_elapsed[s] + 1'b1;
                    end
                    if (pool_elapsed[s] >= pool_limit[s]) begin
                        pool_busy[s]    = 1'b0;
                        hits[hit_count] = s;
                        hit_count++;
                    end
                end
            end
            for (n = 0; n < hit_count; n++) begin
                expiry_reports++;
                expect_result(KIND_EXPIRY, ST_OK, ID_W'(hits[n]), n == hit_count - 1);
            end
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_timer_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (exp_count == 0) begin
                note_mismatch($sformatf("unexpected result kind %0d status %0d id %0d last %0d",
                                        o_kind, o_status, o_result_id, o_last));
            end else begin
                want = fetch_expected();
                if (o_kind !== want.kind || o_status !== want.status ||
                    o_result_id !== want.id || o_last !== want.last) begin
                    note_mismatch($sformatf(
                        "expected kind %0d status %0d id %0d last %0d, got %0d %0d %0d %0d",
                        want.kind, want.status, want.id, want.last,
                        o_kind, o_status, o_result_id, o_last));
                end
            end
        end
    end

    // output back-pressure in bursts
    initial begin : out_stall_gen
        int span;
        forever begin
            if (stall_enable && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 16);
            end else begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span) begin
                @(negedge i_clk);
                if (!stall_enable && !i_out_ready) begin
                    break;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
                                input logic [ID_W-1:0] sid);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_duration_ms <= dur;
        i_slot_id     <= sid;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        requests_sent++;
        predict_pool(op, dur, sid);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_count != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_command_answers();
        send_request(OP_STOP, '0, 4'd15);
        send_request(OP_RESET, '1, 4'd0);
        send_request(OP_TICK, '0, '0);
        // zero duration expires on the first tick
        send_request(OP_START, '0, '1);
        send_request(OP_TICK, '1, 4'd5);
        send_request(OP_START, '1, '0);
        send_request(OP_RESET, '0, 4'd1);
        send_request(OP_STOP, '0, 4'd1);
    endtask

    task automatic test_full_pool();
        int k;
        for (k = 0; k < NUM_TIMERS; k++) begin
            send_request(OP_START, DUR_W'(1), ID_W'(k));
        end
        send_request(OP_START, DUR_W'(7), '0);
        // every slot expires on one tick
        send_request(OP_TICK, '0, '0);
    endtask

    task automatic test_random_mix(input int count);
        int k;
        int pick;
        int s;
        int n;
        logic [OP_W-1:0]  op;
        logic [DUR_W-1:0] dur;
        logic [ID_W-1:0]  sid;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            dur  = DUR_W'($urandom);
            sid  = ID_W'($urandom);
            if (pick < 40) begin
                op = OP_TICK;
            end else if (pick < 72) begin
                op = OP_START;
                case ($urandom_range(0, 9))
                    0: dur = DUR_W'($urandom);
                    1: dur = '1;
                    default: dur = DUR_W'($urandom_range(0, 12));
                endcase
            end else begin
                op = (pick < 86) ? OP_STOP : OP_RESET;
                // mostly aim at a running timer
                if ($urandom_range(0, 3) != 0) begin
                    s = $urandom_range(0, NUM_TIMERS - 1);
                    for (n = 0; n < NUM_TIMERS; n++) begin
                        if (pool_busy[(s + n) % NUM_TIMERS]) begin
                            sid = ID_W'((s + n) % NUM_TIMERS);
                            break;
                        end
                    end
                end
            end
            send_request(op, dur, sid);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_TICK;
        i_duration_ms = '0;
        i_slot_id     = '0;
        idle_enable   = 1'b0;
        stall_enable  = 1'b0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            pool_busy[k]    = 1'b0;
            pool_elapsed[k] = '0;
            pool_limit[k]   = '0;
        end
        pool_next = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_command_answers();
        test_full_pool();
        wait_drained();

        idle_enable  = 1'b1;
        stall_enable = 1'b1;
        test_random_mix(170);
        wait_drained();
        test_random_mix(90);

        // closing stretch with no gaps or stalls
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        test_random_mix(70);
        wait_drained();

        $display("tb: %0d requests, %0d results checked, %0d expiry reports, %0d full-pool answers",
                 requests_sent, results_checked, expiry_reports, full_answers);
        $display("tb: covered idle and running slots, full pool, zero and maximum durations");
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d mismatches", mismatch_count);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
